// File: sv/serial_frame_receiver_core_defines.svh
// Assertion macros used by the frame receiver checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SERIAL_FRAME_RECEIVER_CORE_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sfr_pkg;

    // Receive buffer size; frames longer than this are rejected.
    localparam int BUFFER_BYTES = 256;

    // Framing bytes.
    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] END_BYTE   = 8'h04;

    // Largest payload length that still fits the buffer (length + 7 <= buffer).
    localparam logic [8:0] LEN_LIMIT = 9'(BUFFER_BYTES - 7);

    // Result status codes.
    localparam logic [1:0] ST_ACCEPT   = 2'd0;
    localparam logic [1:0] ST_REJECT   = 2'd1;
    localparam logic [1:0] ST_COMPLETE = 2'd2;

    // Classification of one received byte, decided by the front end.
    typedef enum logic [1:0] {
        K_BYTE    = 2'd0,
        K_PAYLOAD = 2'd1,
        K_REJECT  = 2'd2,
        K_DONE    = 2'd3
    } kind_t;

    // One classified byte as it travels from front end to back end.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] index;
        logic [7:0] id;
        logic [7:0] cmd;
        logic [7:0] len;
    } frame_rec_t;

endpackage

// File: sv/sfr_front.sv
// Front end: frame position tracking, checksum and byte classification.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_ready,
    input  logic [7:0]          rx_byte,
    output logic                push,
    output sfr_pkg::frame_rec_t push_rec,
    input  logic                q_full
);
    import sfr_pkg::*;

    logic [7:0]  pos_reg,  pos_next;
    logic [7:0]  id_reg,   id_next;
    logic [7:0]  cmd_reg,  cmd_next;
    logic [7:0]  len_reg,  len_next;
    logic [15:0] sum_reg,  sum_next;
    logic [7:0]  sum_hi_reg, sum_hi_next;

    logic [8:0]  pos_w;
    logic [8:0]  len_p4;
    logic [8:0]  len_p5;
    logic [8:0]  len_p6;
    logic        oversize;
    logic [15:0] sum_add;
    kind_t       kind;

    assign rx_ready = !q_full;
    assign push     = rx_valid && rx_ready;

    assign pos_w    = {1'b0, pos_reg};
    assign len_p4   = {1'b0, len_reg} + 9'd4;
    assign len_p5   = {1'b0, len_reg} + 9'd5;
    assign len_p6   = {1'b0, len_reg} + 9'd6;
    assign oversize = {1'b0, len_reg} > LEN_LIMIT;
    assign sum_add  = sum_reg + {8'd0, rx_byte};

    // Classify the byte against the current frame position
    always_comb
    begin
        kind        = K_BYTE;
        pos_next    = pos_reg + 8'd1;
        id_next     = id_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        sum_next    = sum_reg;
        sum_hi_next = sum_hi_reg;

        if (pos_reg == 8'd0)
        begin
            if (rx_byte == START_BYTE)
                sum_next = 16'd0;
            else
                kind = K_REJECT;
        end
        else if (pos_reg < 8'd4)
        begin
            case (pos_reg[1:0])
                2'd1:    id_next  = rx_byte;
                2'd2:    cmd_next = rx_byte;
                default: len_next = rx_byte;
            endcase
            sum_next = sum_add;
        end
        else if (oversize)
        begin
            kind = K_REJECT;
        end
        else if (pos_w < len_p4)
        begin
            kind     = K_PAYLOAD;
            sum_next = sum_add;
        end
        else if (pos_w == len_p4)
        begin
            sum_hi_next = rx_byte;
        end
        else if (pos_w == len_p5)
        begin
            if ({sum_hi_reg, rx_byte} != sum_reg)
                kind = K_REJECT;
        end
        else if (pos_w == len_p6 && rx_byte == END_BYTE)
        begin
            kind = K_DONE;
        end
        else
        begin
            kind = K_REJECT;
        end

        // Any status other than a plain accept restarts the parser
        if (kind == K_REJECT || kind == K_DONE)
            pos_next = 8'd0;
    end

    // Build the record pushed into the queue
    always_comb
    begin
        push_rec.kind  = kind;
        push_rec.data  = rx_byte;
        push_rec.index = pos_reg - 8'd4;
        push_rec.id    = id_reg;
        push_rec.cmd   = cmd_reg;
        push_rec.len   = len_reg;
    end

    // Advance parser state on every accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 8'd0;
            id_reg     <= 8'd0;
            cmd_reg    <= 8'd0;
            len_reg    <= 8'd0;
            sum_reg    <= 16'd0;
            sum_hi_reg <= 8'd0;
        end
        else if (push)
        begin
            pos_reg    <= pos_next;
            id_reg     <= id_next;
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            sum_reg    <= sum_next;
            sum_hi_reg <= sum_hi_next;
        end
    end

endmodule

// File: sv/sfr_queue.sv
// Two-entry queue of classified bytes between front end and back end.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sfr_pkg::frame_rec_t push_rec,
    output logic                full,
    output logic                not_empty,
    input  logic                pop,
    output sfr_pkg::frame_rec_t pop_rec
);
    import sfr_pkg::*;

    frame_rec_t  mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign pop_rec   = mem[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed record
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_rec;
    end

endmodule

// File: sv/sfr_back.sv
// Back end: turns classified bytes into result beats in an output register.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  sfr_pkg::frame_rec_t q_rec,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [1:0]          status,
    output logic [7:0]          frame_id,
    output logic [7:0]          frame_cmd,
    output logic [7:0]          frame_len,
    output logic                payload_valid,
    output logic [7:0]          payload_byte,
    output logic [7:0]          payload_index
);
    import sfr_pkg::*;

    logic       valid_reg;
    logic [1:0] status_reg, status_next;
    logic [7:0] id_reg,     id_next;
    logic [7:0] cmd_reg,    cmd_next;
    logic [7:0] len_reg,    len_next;
    logic       pv_reg,     pv_next;
    logic [7:0] pbyte_reg,  pbyte_next;
    logic [7:0] pidx_reg,   pidx_next;

    // Take a new record whenever the output slot is free or being drained
    assign pop = q_not_empty && (!valid_reg || res_ready);

    // Format the result fields from the record kind
    always_comb
    begin
        status_next = ST_ACCEPT;
        id_next     = 8'd0;
        cmd_next    = 8'd0;
        len_next    = 8'd0;
        pv_next     = 1'b0;
        pbyte_next  = 8'd0;
        pidx_next   = 8'd0;
        case (q_rec.kind)
            K_PAYLOAD:
            begin
                pv_next    = 1'b1;
                pbyte_next = q_rec.data;
                pidx_next  = q_rec.index;
            end
            K_REJECT:
            begin
                status_next = ST_REJECT;
            end
            K_DONE:
            begin
                status_next = ST_COMPLETE;
                id_next     = q_rec.id;
                cmd_next    = q_rec.cmd;
                len_next    = q_rec.len;
            end
            default:
            begin
                status_next = ST_ACCEPT;
            end
        endcase
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (res_ready)
            valid_reg <= 1'b0;
    end

    // Output payload, loaded on pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            id_reg     <= id_next;
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            pv_reg     <= pv_next;
            pbyte_reg  <= pbyte_next;
            pidx_reg   <= pidx_next;
        end
    end

    assign res_valid     = valid_reg;
    assign status        = status_reg;
    assign frame_id      = id_reg;
    assign frame_cmd     = cmd_reg;
    assign frame_len     = len_reg;
    assign payload_valid = pv_reg;
    assign payload_byte  = pbyte_reg;
    assign payload_index = pidx_reg;

endmodule

// File: sv/serial_frame_receiver_core.sv
// Top level of the serial frame receiver: front end, queue and back end.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
//
// Usage:
//   Received bytes enter on rx_byte with rx_valid/rx_ready; one result beat
//   leaves per byte on res_valid/res_ready with status, frame header fields
//   and the payload byte with its index.
//   status 0 means the byte was taken, 1 that the frame was dropped and the
//   parser restarted, 2 that a frame with a good checksum and end byte has
//   finished; frame_id, frame_cmd and frame_len are nonzero only then.
//   Payload bytes are streamed as they arrive; drop them unless status 2
//   follows for the same frame.
//   Throughput: one byte per cycle while rx_ready is high, set by the combinational
//   checksum add and position compare in the front end.
//   An accepted byte is written into the two-entry queue and then into the
//   output register, from which its result beat leaves.
//   A stalled res_ready fills the output register and then the queue; rx_ready
//   drops only when the queue is full, and no beat is lost.
//   Reset clears the parser to the idle position and empties queue and output.
`timescale 1ns / 1ps

module serial_frame_receiver_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [1:0] status,
    output logic [7:0] frame_id,
    output logic [7:0] frame_cmd,
    output logic [7:0] frame_len,
    output logic       payload_valid,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index
);
    import sfr_pkg::*;

    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_not_empty;
    frame_rec_t push_rec;
    frame_rec_t pop_rec;

    // Classify incoming beats
    sfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_byte  (rx_byte),
        .push     (push),
        .push_rec (push_rec),
        .q_full   (q_full)
    );

    // Decouple front and back
    sfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (pop),
        .pop_rec   (pop_rec)
    );

    // Produce result beats
    sfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_rec         (pop_rec),
        .pop           (pop),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .status        (status),
        .frame_id      (frame_id),
        .frame_cmd     (frame_cmd),
        .frame_len     (frame_len),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .payload_index (payload_index)
    );

endmodule

// File: sv/sfr_checker.sv
// Port-level checks on the frame receiver result channel, bound to the top.
// Depends on sfr_pkg and serial_frame_receiver_core_defines.svh.
`timescale 1ns / 1ps
`include "serial_frame_receiver_core_defines.svh"

module sfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] status,
    input logic [7:0] frame_id,
    input logic [7:0] frame_cmd,
    input logic [7:0] frame_len,
    input logic       payload_valid,
    input logic [7:0] payload_byte,
    input logic [7:0] payload_index
);
    import sfr_pkg::*;

    // Only defined status codes leave the block
    `SFR_ASSERT_NOW(a_status_code, res_valid, status == ST_ACCEPT || status == ST_REJECT || status == ST_COMPLETE, "undefined status code")

    // A payload beat is always a plain accept
    `SFR_ASSERT_NOW(a_payload_accept, res_valid && payload_valid, status == ST_ACCEPT, "payload beat with non-accept status")

    // Header fields stay zero unless the frame completes
    `SFR_ASSERT_NOW(a_header_zero, res_valid && status != ST_COMPLETE, frame_id == 8'd0 && frame_cmd == 8'd0 && frame_len == 8'd0, "header fields set without completion")

    // Payload fields stay zero outside payload beats
    `SFR_ASSERT_NOW(a_payload_zero, res_valid && !payload_valid, payload_byte == 8'd0 && payload_index == 8'd0, "payload fields set on non-payload beat")

    // A stalled result beat holds
    `SFR_ASSERT_NEXT(a_hold, res_valid && !res_ready, res_valid && $stable(status) && $stable(payload_byte), "result beat changed while stalled")

endmodule

bind serial_frame_receiver_core sfr_checker u_sfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .status        (status),
    .frame_id      (frame_id),
    .frame_cmd     (frame_cmd),
    .frame_len     (frame_len),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .payload_index (payload_index)
);

// File: sim/tb_serial_frame_receiver_core.sv
// Testbench for serial_frame_receiver_core: directed frames, then random frame traffic.
// Depends on sfr_pkg and serial_frame_receiver_core; checks each result beat
// against a built-in frame parser predictor.
`timescale 1ns / 1ps

module tb_serial_frame_receiver_core;

    import sfr_pkg::*;

    // One expected or observed result beat.
    typedef struct packed {
        logic [1:0] st;
        logic [7:0] id;
        logic [7:0] cmd;
        logic [7:0] len;
        logic       pv;
        logic [7:0] pbyte;
        logic [7:0] pidx;
    } frame_result_t;

    // One directed stimulus row; want is used only when typed is set.
    typedef struct packed {
        logic [7:0]    b;
        logic          typed;
        frame_result_t want;
    } dir_row_t;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RAND_ITEMS  = 600;
    localparam int PRINT_LIMIT = 40;

    localparam frame_result_t R_ACCEPT  = '0;
    localparam frame_result_t R_REJECT  = {ST_REJECT, 41'd0};
    localparam frame_result_t R_PAY_FF  = {ST_ACCEPT, 24'd0, 1'b1, 8'hFF, 8'h00};
    localparam frame_result_t R_DONE_FF = {ST_COMPLETE, 8'hFF, 8'h00, 8'h01, 17'd0};

    // Directed frames: idle garbage, a one-byte frame at the byte extremes,
    // a checksum mismatch, an oversized length whose rejected byte is a start
    // byte, and a bad end byte.
    localparam int DIR_ROWS = 28;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        {8'h00, 1'b1, R_REJECT},
        {8'h01, 1'b1, R_ACCEPT},
        {8'hFF, 1'b0, R_ACCEPT},
        {8'h00, 1'b0, R_ACCEPT},
        {8'h01, 1'b0, R_ACCEPT},
        {8'hFF, 1'b1, R_PAY_FF},
        {8'h01, 1'b0, R_ACCEPT},
        {8'hFF, 1'b0, R_ACCEPT},
        {8'h04, 1'b1, R_DONE_FF},
        {8'h01, 1'b0, R_ACCEPT},
        {8'h02, 1'b0, R_ACCEPT},
        {8'h03, 1'b0, R_ACCEPT},
        {8'h00, 1'b0, R_ACCEPT},
        {8'h00, 1'b0, R_ACCEPT},
        {8'h00, 1'b1, R_REJECT},
        {8'h01, 1'b0, R_ACCEPT},
        {8'h00, 1'b0, R_ACCEPT},
        {8'h00, 1'b0, R_ACCEPT},
        {8'hFF, 1'b0, R_ACCEPT},
        {8'h01, 1'b1, R_REJECT},
        {8'h00, 1'b1, R_REJECT},
        {8'h01, 1'b0, R_ACCEPT},
        {8'h00, 1'b0, R_ACCEPT},
        {8'h00, 1'b0, R_ACCEPT},
        {8'h00, 1'b0, R_ACCEPT},
        {8'h00, 1'b0, R_ACCEPT},
        {8'h00, 1'b0, R_ACCEPT},
        {8'hFF, 1'b1, R_REJECT}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       rx_valid = 1'b0;
    logic       rx_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic [1:0] status;
    logic [7:0] frame_id;
    logic [7:0] frame_cmd;
    logic [7:0] frame_len;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;

    // Predictor state: parser position, header bytes and checksum.
    logic [7:0]  parse_pos = '0;
    logic [7:0]  hdr_id = '0;
    logic [7:0]  hdr_cmd = '0;
    logic [7:0]  hdr_len = '0;
    logic [15:0] sum_acc = '0;
    logic [7:0]  sum_hi = '0;

    frame_result_t pending_results [$];
    frame_result_t cur_want = '0;
    logic          cur_typed = 1'b0;

    int err_count = 0;
    int cycle_count = 0;
    int rand_items = 0;
    int burst_left = 0;
    int rdy_mode = 0;
    int rdy_mode_left = 0;
    int rdy_stall_left = 0;
    bit mid_drain_done = 1'b0;

    serial_frame_receiver_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_valid),
        .rx_ready      (rx_ready),
        .rx_byte       (rx_byte),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .status        (status),
        .frame_id      (frame_id),
        .frame_cmd     (frame_cmd),
        .frame_len     (frame_len),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .payload_index (payload_index)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the parser by one byte and return the result it produces.
    function automatic frame_result_t parse_byte(input logic [7:0] b);
        frame_result_t r;
        int            pos;
        int            len;
        r   = '0;
        pos = int'(parse_pos);
        len = int'(hdr_len);
        r.st = ST_ACCEPT;
        if (pos == 0)
        begin
            if (b == START_BYTE)
                sum_acc = '0;
            else
                r.st = ST_REJECT;
        end
        else if (pos < 4)
        begin
            if (pos == 1)
                hdr_id = b;
            else if (pos == 2)
                hdr_cmd = b;
            else
                hdr_len = b;
            sum_acc = sum_acc + 16'(b);
        end
        else if (len + 7 > BUFFER_BYTES)
            r.st = ST_REJECT;
        else if (pos < 4 + len)
        begin
            sum_acc = sum_acc + 16'(b);
            r.pv    = 1'b1;
            r.pbyte = b;
            r.pidx  = 8'(pos - 4);
        end
        else if (pos == 4 + len)
            sum_hi = b;
        else if (pos == 5 + len)
        begin
            if ({sum_hi, b} != sum_acc)
                r.st = ST_REJECT;
        end
        else if (pos == 6 + len && b == END_BYTE)
            r.st = ST_COMPLETE;
        else
            r.st = ST_REJECT;

        if (r.st == ST_COMPLETE)
        begin
            r.id  = hdr_id;
            r.cmd = hdr_cmd;
            r.len = hdr_len;
        end
        if (r.st != ST_ACCEPT)
            parse_pos = '0;
        else
            parse_pos = parse_pos + 8'd1;
        return r;
    endfunction

    // Print one mismatch line (up to a cap) and count it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    endtask

    task automatic check_result(input frame_result_t got, input frame_result_t want);
        if (got.st != want.st)
            report_mismatch("status", got.st, want.st);
        if (got.id != want.id)
            report_mismatch("frame_id", got.id, want.id);
        if (got.cmd != want.cmd)
            report_mismatch("frame_cmd", got.cmd, want.cmd);
        if (got.len != want.len)
            report_mismatch("frame_len", got.len, want.len);
        if (got.pv != want.pv)
            report_mismatch("payload_valid", got.pv, want.pv);
        if (got.pbyte != want.pbyte)
            report_mismatch("payload_byte", got.pbyte, want.pbyte);
        if (got.pidx != want.pidx)
            report_mismatch("payload_index", got.pidx, want.pidx);
    endtask

    // Predict on each accepted byte, then check each accepted result beat.
    always @(posedge clk)
    begin
        frame_result_t pred;
        frame_result_t got;
        if (rst_n)
        begin
            if (rx_valid && rx_ready)
            begin
                pred = parse_byte(rx_byte);
                pending_results.push_back(cur_typed ? cur_want : pred);
            end
            if (res_valid && res_ready)
            begin
                got = {status, frame_id, frame_cmd, frame_len,
                       payload_valid, payload_byte, payload_index};
                if (pending_results.size() == 0)
                    report_mismatch("result beat with nothing pending", got, 0);
                else
                    check_result(got, pending_results.pop_front());
            end
        end
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_serial_frame_receiver_core failed");
            $finish;
        end
    end

    // Receiver: always ready, coin-flip ready, or occasional long stalls.
    always @(negedge clk)
    begin
        if (rdy_mode_left == 0)
        begin
            rdy_mode      = $urandom_range(0, 2);
            rdy_mode_left = $urandom_range(20, 120);
        end
        rdy_mode_left--;
        case (rdy_mode)
            0: res_ready <= 1'b1;
            1: res_ready <= 1'($urandom_range(0, 1));
            default:
            begin
                if (rdy_stall_left > 0)
                begin
                    res_ready <= 1'b0;
                    rdy_stall_left--;
                end
                else
                begin
                    res_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        rdy_stall_left = $urandom_range(1, 30);
                end
            end
        endcase
    end

    // Send one beat; between bursts, usually insert an idle gap.
    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input frame_result_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                rx_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
        end
        @(negedge clk);
        rx_valid  <= 1'b1;
        rx_byte   <= b;
        cur_typed = typed;
        cur_want  = want;
        do
            @(posedge clk);
        while (!rx_ready);
        burst_left--;
    endtask

    // Hold the sender until every pending result has been delivered.
    task automatic wait_results_done();
        @(negedge clk);
        rx_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    // Build and send one random frame: mostly good, some broken, some noise.
    task automatic send_random_frame();
        logic [7:0]  fb [$];
        logic [15:0] sum;
        logic [7:0]  b;
        int          kind;
        int          pick;
        int          len;
        int          n;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            // line noise
            n = $urandom_range(1, 4);
            repeat (n) fb.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind < 15)
        begin
            // oversized length, followed by a few bytes
            fb.push_back(START_BYTE);
            fb.push_back(8'($urandom_range(0, 255)));
            fb.push_back(8'($urandom_range(0, 255)));
            fb.push_back(8'($urandom_range(250, 255)));
            n = $urandom_range(1, 3);
            repeat (n) fb.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                len = $urandom_range(0, 8);
            else if (pick < 95)
                len = $urandom_range(9, 40);
            else if (pick < 98)
                len = $urandom_range(200, 248);
            else
                len = 249;
            fb.push_back(START_BYTE);
            fb.push_back(8'($urandom_range(0, 255)));
            fb.push_back(8'($urandom_range(0, 255)));
            fb.push_back(8'(len));
            sum = 16'(fb[1]) + 16'(fb[2]) + 16'(fb[3]);
            repeat (len)
            begin
                b = 8'($urandom_range(0, 255));
                fb.push_back(b);
                sum = sum + 16'(b);
            end
            // corrupt the checksum
            if (kind < 25)
                sum = sum ^ 16'($urandom_range(1, 65535));
            fb.push_back(sum[15:8]);
            fb.push_back(sum[7:0]);
            // corrupt the end byte
            if (kind >= 25 && kind < 35)
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == END_BYTE);
                fb.push_back(b);
            end
            else
                fb.push_back(END_BYTE);
            // cut the frame short
            if (kind >= 35 && kind < 45)
            begin
                n = $urandom_range(1, fb.size() - 1);
                while (fb.size() > n)
                    void'(fb.pop_back());
            end
        end
        foreach (fb[i])
        begin
            send_byte(fb[i], 1'b0, R_ACCEPT);
            rand_items++;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(DIR_TABLE[i].b, DIR_TABLE[i].typed, DIR_TABLE[i].want);
        wait_results_done();

        // random frames, with one full drain midway
        while (rand_items < RAND_ITEMS)
        begin
            send_random_frame();
            if (!mid_drain_done && rand_items >= RAND_ITEMS / 2)
            begin
                wait_results_done();
                mid_drain_done = 1'b1;
            end
        end

        // drain and let the pipeline settle
        @(negedge clk);
        rx_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);

        if (err_count == 0)
            $display("tb_serial_frame_receiver_core passed");
        else
            $display("tb_serial_frame_receiver_core failed");
        $finish;
    end

endmodule
